// File: rtl/dpr_pkg.sv
// Shared constants, codes and control types for the disc placement and raster block.
`default_nettype none

package dpr_pkg;

    // Table depth and coordinate format (unsigned Q12.8).
    localparam int MAX_DISCS      = 64;
    localparam int COORD_INT_BITS = 12;
    localparam int FRAC_BITS      = 8;
    localparam int COORD_W        = COORD_INT_BITS + FRAC_BITS;
    localparam int SQ_W           = 2 * COORD_W;
    localparam int DIST_W         = SQ_W + 1;
    localparam int IDX_W          = (MAX_DISCS > 1) ? $clog2(MAX_DISCS) : 1;
    localparam int CNT_W          = $clog2(MAX_DISCS + 1);
    localparam int HALF_PIXEL     = 1 << (FRAC_BITS - 1);

    // Attempt budget: max(MIN_TRIES, TRIES_PER_DISC * target).
    localparam int TRIES_PER_DISC = 100;
    localparam int MIN_TRIES      = 100;
    localparam int ATT_W          = $clog2(TRIES_PER_DISC * MAX_DISCS + 1);

    // Register field widths.
    localparam int TARGET_W = 7;
    localparam int HEIGHT_W = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Stream payload widths.
    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = 2 * COORD_W + 2 * COORD_INT_BITS;
    localparam int RES_W      = 1 + 7 + 1 + HEIGHT_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_CAND  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINDIST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the incoming request
        logic setup;    // compute threshold and eligibility, reset scan
        logic issue;    // read the next stored centre
        logic commit;   // update counts and tables, capture the result
        logic respond;  // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_needed;  // request must visit the stored centres
        logic last_issue;   // current read is the last stored centre
        logic pipe_busy;    // distance pipeline still holds work
        logic out_free;     // output register can take a new result
    } t_status;

endpackage

`default_nettype wire

// File: rtl/dpr_ctrl.sv
// Controller state machine that sequences one request through the distance datapath.
`default_nettype none

module dpr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  dpr_pkg::t_status     i_status,
    output logic                 o_req_ready,
    output dpr_pkg::t_cmd        o_cmd
);
    import dpr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SETUP   = 6'b000010,
        S_SCAN    = 6'b000100,
        S_DRAIN   = 6'b001000,
        S_FINISH  = 6'b010000,
        S_RESPOND = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_req_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_status.scan_needed ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.commit = 1'b1;
                n_state      = S_RESPOND;
            end
            S_RESPOND: begin
                if (i_status.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dpr_datapath.sv
// Datapath: configuration registers, centre tables, distance unit, counters and result register.
`default_nettype none

module dpr_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [dpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dpr_pkg::CFG_W-1:0]         i_cfg_data,
    // Request fields
    input  wire logic [dpr_pkg::OP_W-1:0]          i_op,
    input  wire logic [dpr_pkg::COORD_W-1:0]       i_cand_x,
    input  wire logic [dpr_pkg::COORD_W-1:0]       i_cand_y,
    input  wire logic [dpr_pkg::COORD_INT_BITS-1:0] i_pix_x,
    input  wire logic [dpr_pkg::COORD_INT_BITS-1:0] i_pix_y,
    // Control
    input  dpr_pkg::t_cmd                          i_cmd,
    output dpr_pkg::t_status                       o_status,
    // Result output
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [dpr_pkg::RES_W-1:0]              o_out_data
);
    import dpr_pkg::*;

    // Configuration registers.
    logic [TARGET_W-1:0] r_target;
    logic [COORD_W-1:0]  r_radius;
    logic [COORD_W-1:0]  r_min_dist;
    logic [HEIGHT_W-1:0] r_height;

    // Request registers.
    t_op                 r_op;
    logic [COORD_W-1:0]  r_pt_x;
    logic [COORD_W-1:0]  r_pt_y;
    logic [SQ_W-1:0]     r_thr;
    logic                r_elig;

    // Placement state.
    logic [CNT_W-1:0]    r_stored;
    logic [ATT_W-1:0]    r_attempt;

    // Scan pipeline.
    logic [CNT_W-1:0]    r_idx;
    logic                r_v1;
    logic                r_v2;
    logic [COORD_W-1:0]  r_mx;
    logic [COORD_W-1:0]  r_my;
    logic [SQ_W-1:0]     r_dx2;
    logic [SQ_W-1:0]     r_dy2;
    logic                r_hit;

    // Result capture and output register.
    logic                r_res_acc;
    logic [HEIGHT_W-1:0] r_res_surface;
    logic                r_out_valid;
    logic [RES_W-1:0]    r_out_data;

    // Centre tables.
    logic [COORD_W-1:0]  mem_x [MAX_DISCS];
    logic [COORD_W-1:0]  mem_y [MAX_DISCS];

    logic [ATT_W-1:0]    eff_target;
    logic [ATT_W-1:0]    tries;
    logic [ATT_W-1:0]    limit;
    logic                elig_now;
    logic                spent;
    logic [COORD_W-1:0]  thr_sel;
    logic [COORD_W-1:0]  dx;
    logic [COORD_W-1:0]  dy;
    logic [DIST_W-1:0]   dist_sum;
    logic                cmp_hit;
    logic                do_store;
    logic                do_count;

    // Effective target and attempt budget from the current registers.
    always_comb begin
        eff_target = (ATT_W'(r_target) > ATT_W'(MAX_DISCS)) ? ATT_W'(MAX_DISCS)
                                                             : ATT_W'(r_target);
        tries      = ATT_W'(eff_target * ATT_W'(TRIES_PER_DISC));
        limit      = (tries > ATT_W'(MIN_TRIES)) ? tries : ATT_W'(MIN_TRIES);
        elig_now   = (ATT_W'(r_stored) < eff_target) && (r_attempt < limit);
        spent      = (r_attempt >= limit) && (ATT_W'(r_stored) < eff_target);
        thr_sel    = (r_op == OP_PIXEL) ? r_radius : r_min_dist;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_radius   <= COORD_W'(1 << FRAC_BITS);
            r_min_dist <= '0;
            r_height   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET:  r_target   <= i_cfg_data[TARGET_W-1:0];
                CFG_RADIUS:  r_radius   <= i_cfg_data[COORD_W-1:0];
                CFG_MINDIST: r_min_dist <= i_cfg_data[COORD_W-1:0];
                CFG_HEIGHT:  r_height   <= i_cfg_data[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Latch the request; pixel queries become pixel-centre coordinates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= t_op'(i_op);
            if (t_op'(i_op) == OP_PIXEL) begin
                r_pt_x <= {i_pix_x, {FRAC_BITS{1'b0}}} + COORD_W'(HALF_PIXEL);
                r_pt_y <= {i_pix_y, {FRAC_BITS{1'b0}}} + COORD_W'(HALF_PIXEL);
            end else begin
                r_pt_x <= i_cand_x;
                r_pt_y <= i_cand_y;
            end
        end
    end

    // Squared threshold and eligibility, taken once per request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_thr  <= SQ_W'(thr_sel) * SQ_W'(thr_sel);
            r_elig <= elig_now;
        end
    end

    // Scan index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.setup) begin
            r_idx <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // Table read port, registered data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_mx <= mem_x[r_idx[IDX_W-1:0]];
            r_my <= mem_y[r_idx[IDX_W-1:0]];
        end
    end

    // Table write port: a surviving candidate goes to the next free entry.
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            mem_x[r_stored[IDX_W-1:0]] <= r_pt_x;
            mem_y[r_stored[IDX_W-1:0]] <= r_pt_y;
        end
    end

    // Distance unit: absolute differences and squares.
    always_comb begin
        dx       = (r_mx >= r_pt_x) ? (r_mx - r_pt_x) : (r_pt_x - r_mx);
        dy       = (r_my >= r_pt_y) ? (r_my - r_pt_y) : (r_pt_y - r_my);
        dist_sum = DIST_W'(r_dx2) + DIST_W'(r_dy2);
        cmp_hit  = (r_op == OP_PIXEL) ? (dist_sum <= DIST_W'(r_thr))
                                      : (dist_sum <  DIST_W'(r_thr));
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_dx2 <= SQ_W'(dx) * SQ_W'(dx);
            r_dy2 <= SQ_W'(dy) * SQ_W'(dy);
        end
    end

    // Pipeline valids and hit accumulation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.setup) begin
                r_hit <= 1'b0;
            end else if (r_v2 && cmp_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Commit decisions.
    assign do_count = i_cmd.commit && (r_op == OP_CAND) && r_elig;
    assign do_store = do_count && !r_hit;

    // Placement counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored  <= '0;
            r_attempt <= '0;
        end else if (i_cmd.commit && (r_op == OP_CLEAR)) begin
            r_stored  <= '0;
            r_attempt <= '0;
        end else begin
            if (do_count) begin
                r_attempt <= r_attempt + ATT_W'(1);
            end
            if (do_store) begin
                r_stored <= r_stored + CNT_W'(1);
            end
        end
    end

    // Per-request result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_acc     <= do_store;
            r_res_surface <= ((r_op == OP_PIXEL) && r_hit) ? r_height : '0;
        end
    end

    // Output register, packed accepted, count, spent flag, surface.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.respond) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_out_data <= {r_res_surface, spent, 7'(r_stored), r_res_acc};
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.scan_needed = (r_stored != '0) &&
                               ((r_op == OP_PIXEL) || ((r_op == OP_CAND) && elig_now));
        o_status.last_issue  = (r_idx + CNT_W'(1)) == r_stored;
        o_status.pipe_busy   = r_v1 || r_v2;
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/disc_placement_and_raster.sv
// Top level of the disc placement and raster block.
//
// Places disc centres by dart throwing and rasterizes them. Each request (candidate centre,
// pixel query or clear) gives exactly one result. A pixel query, or a candidate while
// placement is still open, visits every stored centre with one distance unit, one centre
// per cycle; clear, unused codes and requests that need no visit skip the scan. A result
// held by the sink keeps the request waiting until the output register is free. One
// request is in work at a time, and a new request is taken while the previous result
// still waits in the output register. The centre tables have no reset; only entries
// below the stored count are ever read. Configuration writes are taken in any cycle and
// must be made while the block is idle.
`default_nettype none

module disc_placement_and_raster (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Request stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata, lowest bit up: cand_x[19:0], cand_y[39:20], pix_x[51:40], pix_y[63:52]
    input  wire logic [dpr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [dpr_pkg::OP_W-1:0]           s_axis_tuser,
    // Result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata, lowest bit up: accepted[0], disc_count[7:1], attempts_spent[8],
    // surface_value[40:9], zero fill [47:41]
    output logic [dpr_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // Configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [dpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [dpr_pkg::CFG_W-1:0]          i_cfg_data
);
    import dpr_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [RES_W-1:0] res_data;

    // Configuration is always accepted.
    assign o_cfg_ready = 1'b1;

    dpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_status    (status),
        .o_req_ready (s_axis_tready),
        .o_cmd       (cmd)
    );

    dpr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_cand_x    (s_axis_tdata[COORD_W-1:0]),
        .i_cand_y    (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_pix_x     (s_axis_tdata[2*COORD_W+COORD_INT_BITS-1:2*COORD_W]),
        .i_pix_y     (s_axis_tdata[IN_DATA_W-1:2*COORD_W+COORD_INT_BITS]),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (res_data)
    );

    // Zero fill to whole bytes.
    assign m_axis_tdata = OUT_DATA_W'(res_data);

endmodule

`default_nettype wire

// File: rtl/dpr_checker.sv
// Port-level checks for the disc placement and raster block, bound to the top level.
`default_nettype none

module dpr_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [dpr_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import dpr_pkg::*;

    // A result held back by the sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Requests are worked one at a time: none is taken in the cycle after one is.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // A stored candidate leaves at least one centre in the tables.
    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[7:1] != 7'd0))
        else $error("accepted candidate with empty table");

    // A pixel height never comes with an accepted candidate.
    a_surface_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[40:9] != 32'd0) |-> !m_axis_tdata[0])
        else $error("surface value reported on a candidate result");

    // The count never passes the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] <= 7'(MAX_DISCS)))
        else $error("disc count beyond table depth");

endmodule

bind disc_placement_and_raster dpr_checker u_dpr_checker (.*);

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the disc placement and raster block.
`timescale 1ns / 1ps

module tb;
    import dpr_pkg::*;

    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 4000;
    // Length of the long receiver hold-off, in cycles.
    localparam int LONG_HOLD = 400;
    // Drain time after the last result.
    localparam int TAIL_CYCLES = 100;

    // One request as the sender sees it.
    typedef struct packed {
        t_op               op;
        logic [COORD_W-1:0] cand_x;
        logic [COORD_W-1:0] cand_y;
        logic [11:0]       pix_x;
        logic [11:0]       pix_y;
    } t_disc_req;

    // One result: placement status plus the rasterized value.
    typedef struct packed {
        logic        accepted;
        logic [6:0]  disc_count;
        logic        spent;
        logic [31:0] surface;
    } t_disc_status;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    disc_placement_and_raster u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Stimulus backlog and predicted results.
    t_disc_req    req_backlog[$];
    t_disc_status predicted_status[$];

    // Predictor copy of the registers and placement state.
    logic [6:0]         cfg_target = 7'd0;
    logic [COORD_W-1:0] cfg_radius = 20'd256;
    logic [COORD_W-1:0] cfg_min_dist = 20'd0;
    logic [31:0]        cfg_height = 32'd0;
    logic [COORD_W-1:0] placed_x[MAX_DISCS];
    logic [COORD_W-1:0] placed_y[MAX_DISCS];
    int                 placed_count = 0;
    int                 tries_spent = 0;

    // Stimulus shaping.
    logic [COORD_W-1:0] win_x, win_y, win_span;
    logic [COORD_W-1:0] last_cx = '0, last_cy = '0;
    int                 clear_odds = 0;
    int                 wide_odds = 8;
    bit                 idle_enable = 1'b1;
    int                 hold_req = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;

    // Bookkeeping.
    bit req_taken = 1'b0;
    int reqs_issued = 0;
    int results_checked = 0;
    int error_count = 0;
    int quiet_cycles = 0;
    int cfg_writes = 0;
    int n_stored = 0;
    int n_hits = 0;
    int n_spent = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned dist_sq(input longint unsigned ax, ay, bx, by);
        longint unsigned dx, dy;
        dx = (ax >= bx) ? ax - bx : bx - ax;
        dy = (ay >= by) ? ay - by : by - ay;
        return dx * dx + dy * dy;
    endfunction

    // Predict the result of one request and advance the placement state.
    function automatic t_disc_status compute_disc_status(input t_op op,
            input logic [COORD_W-1:0] cx, cy, input logic [11:0] px, py);
        t_disc_status    res;
        longint unsigned thresh, ctr_x, ctr_y;
        int              goal, budget, i;
        bit              clear_path;
        res = '0;
        goal = (cfg_target < MAX_DISCS) ? int'(cfg_target) : MAX_DISCS;
        budget = (TRIES_PER_DISC * goal > MIN_TRIES) ? TRIES_PER_DISC * goal : MIN_TRIES;
        case (op)
            OP_CAND: begin
                // Dart throw: one attempt, stored only if clear of every centre.
                if (placed_count < goal && tries_spent < budget) begin
                    tries_spent++;
                    thresh = longint'(cfg_min_dist);
                    thresh = thresh * thresh;
                    clear_path = 1'b1;
                    for (i = 0; i < placed_count; i++) begin
                        if (dist_sq(cx, cy, placed_x[i], placed_y[i]) < thresh) begin
                            clear_path = 1'b0;
                            break;
                        end
                    end
                    if (clear_path) begin
                        placed_x[placed_count] = cx;
                        placed_y[placed_count] = cy;
                        placed_count++;
                        res.accepted = 1'b1;
                    end
                end
            end
            OP_PIXEL: begin
                // Test the pixel centre against every stored disc.
                ctr_x = (longint'(px) << FRAC_BITS) + HALF_PIXEL;
                ctr_y = (longint'(py) << FRAC_BITS) + HALF_PIXEL;
                thresh = longint'(cfg_radius);
                thresh = thresh * thresh;
                for (i = 0; i < placed_count; i++) begin
                    if (dist_sq(ctr_x, ctr_y, placed_x[i], placed_y[i]) <= thresh) begin
                        res.surface = cfg_height;
                        break;
                    end
                end
            end
            OP_CLEAR: begin
                placed_count = 0;
                tries_spent = 0;
            end
            default: ;
        endcase
        res.disc_count = placed_count[6:0];
        res.spent = (tries_spent >= budget) && (placed_count < goal);
        return res;
    endfunction

    function automatic void check_field(input string fname, input longint unsigned want,
            input longint unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
        end
    endfunction

    // Request driver: a request stays offered until it is taken.
    always @(negedge i_clk) begin
        t_disc_req req;
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (req_backlog.size() != 0 && !(idle_enable && $urandom_range(0, 99) < 25)) begin
                req = req_backlog.pop_front();
                reqs_issued++;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {req.pix_y, req.pix_x, req.cand_y, req.cand_x};
                s_axis_tuser <= req.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_enable && $urandom_range(0, 99) < 25);
        end
    end

    // Monitor: check each result, then predict for each taken request.
    always @(posedge i_clk) begin
        t_disc_status got, want, pred;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.accepted = m_axis_tdata[0];
                got.disc_count = m_axis_tdata[7:1];
                got.spent = m_axis_tdata[8];
                got.surface = m_axis_tdata[40:9];
                results_checked++;
                if (predicted_status.size() == 0) begin
                    error_count++;
                    $display("%0t ns: result with none outstanding, expected nothing, actual 0x%0h",
                             $time, m_axis_tdata);
                end else begin
                    want = predicted_status.pop_front();
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("disc_count", want.disc_count, got.disc_count);
                    check_field("attempts_spent", want.spent, got.spent);
                    check_field("surface_value", want.surface, got.surface);
                    n_stored += got.accepted;
                    n_spent += got.spent;
                    n_hits += (got.surface != 0);
                end
            end
            req_taken = s_axis_tvalid && s_axis_tready;
            if (req_taken) begin
                pred = compute_disc_status(t_op'(s_axis_tuser),
                    s_axis_tdata[19:0], s_axis_tdata[39:20],
                    s_axis_tdata[51:40], s_axis_tdata[63:52]);
                predicted_status = {predicted_status, pred};
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("disc_placement_and_raster verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void queue_req(input t_op op, input logic [COORD_W-1:0] cx, cy,
            input logic [11:0] px, py);
        t_disc_req r;
        r.op = op;
        r.cand_x = cx;
        r.cand_y = cy;
        r.pix_x = px;
        r.pix_y = py;
        req_backlog = {req_backlog, r};
        if (op == OP_CAND) begin
            last_cx = cx;
            last_cy = cy;
        end
    endfunction

    // Write one register and mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_TARGET:  cfg_target = value[6:0];
            CFG_RADIUS:  cfg_radius = value[COORD_W-1:0];
            CFG_MINDIST: cfg_min_dist = value[COORD_W-1:0];
            CFG_HEIGHT:  cfg_height = value;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued request has been sent and answered.
    task automatic wait_drained();
        do @(negedge i_clk); while (req_backlog.size() != 0 || reqs_issued != results_checked);
    endtask

    // Fill the backlog: a clear, then clustered darts and pixel probes with some noise.
    task automatic fill_requests(input int n_items);
        int                 pick, k;
        logic [COORD_W-1:0] cx, cy;
        logic [11:0]        px, py;
        queue_req(OP_CLEAR, '0, '0, '0, '0);
        for (k = 1; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            cx = win_x + COORD_W'($urandom_range(0, win_span));
            cy = win_y + COORD_W'($urandom_range(0, win_span));
            if (pick < clear_odds) begin
                queue_req(OP_CLEAR, cx, cy, cx[19:8], cy[19:8]);
            end else if (pick < clear_odds + 2) begin
                queue_req(OP_NONE, COORD_W'($urandom), COORD_W'($urandom),
                          12'($urandom), 12'($urandom));
            end else if (pick < 54) begin
                if ($urandom_range(0, 99) < wide_odds) begin
                    cx = COORD_W'($urandom_range(0, 20'hFFFFF));
                    cy = COORD_W'($urandom_range(0, 20'hFFFFF));
                end else if ($urandom_range(0, 4) == 0) begin
                    // Snap onto a pixel centre so zero-radius probes can land exactly.
                    cx[7:0] = 8'(HALF_PIXEL);
                    cy[7:0] = 8'(HALF_PIXEL);
                end
                queue_req(OP_CAND, cx, cy, 12'($urandom), 12'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < wide_odds) begin
                    px = 12'($urandom_range(0, 4095));
                    py = 12'($urandom_range(0, 4095));
                end else if (pick < 50) begin
                    px = last_cx[19:8] + 12'($urandom_range(0, 2)) - 12'd1;
                    py = last_cy[19:8] + 12'($urandom_range(0, 2)) - 12'd1;
                end else begin
                    px = cx[19:8];
                    py = cy[19:8];
                end
                queue_req(OP_PIXEL, COORD_W'($urandom), COORD_W'($urandom), px, py);
            end
        end
    endtask

    task automatic run_phase(input logic [6:0] target, input logic [COORD_W-1:0] rad, mind,
            input logic [31:0] height, input logic [COORD_W-1:0] span, input int clears,
            input int wide, input bit long_hold, input int n_items);
        write_reg(CFG_TARGET, 32'(target));
        write_reg(CFG_RADIUS, 32'(rad));
        write_reg(CFG_MINDIST, 32'(mind));
        write_reg(CFG_HEIGHT, height);
        win_span = span;
        win_x = COORD_W'($urandom_range(0, 20'hFFFFF - span));
        win_y = COORD_W'($urandom_range(0, 20'hFFFFF - span));
        clear_odds = clears;
        wide_odds = wide;
        if (long_hold) hold_req++;
        fill_requests(n_items);
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: target zero, so a dart is ignored.
        queue_req(OP_NONE, '0, '0, '0, '0);
        queue_req(OP_CAND, 20'h00100, 20'h00100, '0, '0);
        wait_drained();

        // Small target with spacing: boundary spacing, finished placement, extremes.
        write_reg(CFG_TARGET, 32'd3);
        write_reg(CFG_RADIUS, 32'h0000_0200);
        write_reg(CFG_MINDIST, 32'h0000_0100);
        write_reg(CFG_HEIGHT, 32'h7FFF_FFFF);
        queue_req(OP_PIXEL, '0, '0, 12'd0, 12'd0);
        queue_req(OP_CAND, 20'h00000, 20'h00000, '0, '0);
        queue_req(OP_CAND, 20'hFFFFF, 20'hFFFFF, '0, '0);
        queue_req(OP_CAND, 20'h00080, 20'h00080, '0, '0);
        queue_req(OP_CAND, 20'h00100, 20'h00000, '0, '0);
        queue_req(OP_CAND, 20'h00500, 20'h00500, '0, '0);
        queue_req(OP_PIXEL, '0, '0, 12'd0, 12'd0);
        queue_req(OP_PIXEL, '0, '0, 12'd4095, 12'd4095);
        queue_req(OP_PIXEL, '0, '0, 12'd2048, 12'd2048);
        queue_req(OP_CLEAR, '0, '0, '0, '0);
        queue_req(OP_PIXEL, '0, '0, 12'd0, 12'd0);
        wait_drained();

        // Target above the table, zero radius and zero spacing.
        write_reg(CFG_TARGET, 32'd127);
        write_reg(CFG_RADIUS, 32'h0000_0000);
        write_reg(CFG_MINDIST, 32'h0000_0000);
        write_reg(CFG_HEIGHT, 32'h8000_0000);
        queue_req(OP_CAND, 20'h00180, 20'h00280, '0, '0);
        queue_req(OP_CAND, 20'h00180, 20'h00280, '0, '0);
        queue_req(OP_PIXEL, '0, '0, 12'd1, 12'd2);
        queue_req(OP_PIXEL, '0, '0, 12'd2, 12'd1);
        queue_req(OP_PIXEL, '0, '0, 12'd1, 12'd3);
        queue_req(OP_CAND, 20'h7FF80, 20'h00080, '0, '0);
        queue_req(OP_PIXEL, '0, '0, 12'h7FF, 12'd0);
        queue_req(OP_NONE, 20'hFFFFF, 20'hFFFFF, 12'hFFF, 12'hFFF);
        wait_drained();

        // Random phases over a range of settings.
        run_phase(7'd64, 20'h00300, 20'h00200, 32'h7FFF_FFFF, 20'h04000, 0, 8, 1'b0, 200);
        // No idling on either side here; tight cluster exhausts the attempt budget.
        idle_enable = 1'b0;
        run_phase(7'd2, 20'h00100, 20'h01000, 32'h8000_0000, 20'h00600, 0, 0, 1'b0, 420);
        idle_enable = 1'b1;
        run_phase(7'd127, 20'hFFFFF, 20'h00000, $urandom, 20'hFFFFF, 0, 8, 1'b1, 180);
        run_phase(7'd0, 20'h00001, 20'hFFFFF, $urandom, 20'h02000, 1, 8, 1'b0, 60);
        run_phase(7'd40, 20'h00000, 20'h00000, $urandom, 20'h00800, 0, 8, 1'b0, 180);
        run_phase(7'd1, 20'h00001, 20'hFFFFF, 32'hFFFF_FFFF, 20'h01000, 0, 8, 1'b0, 100);
        run_phase(7'($urandom_range(3, 30)), COORD_W'($urandom_range(20'h00080, 20'h01000)),
                  COORD_W'($urandom_range(20'h00080, 20'h00800)), $urandom, 20'h03000,
                  2, 8, 1'b0, 200);
        run_phase(7'd64, COORD_W'($urandom_range(20'h00100, 20'h00800)), 20'h00100, $urandom,
                  20'h02000, 1, 8, 1'b0, 180);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (predicted_status.size() != 0) begin
            error_count++;
            $display("%0t ns: %0d results never arrived", $time, predicted_status.size());
        end
        $display("Run covered %0d requests and %0d register writes over eleven settings.",
                 reqs_issued, cfg_writes);
        $display("Centres stored: %0d, pixel hits: %0d, results with budget spent: %0d.",
                 n_stored, n_hits, n_spent);
        if (error_count == 0) begin
            $display("disc_placement_and_raster verification clean");
        end else begin
            $display("disc_placement_and_raster verification failed");
        end
        $finish;
    end

endmodule
